FILE: design/fcce_pkg.sv
package fcce_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 4096;

  localparam logic [15:0] FREE_MARK  = 16'h0000;
  localparam logic [15:0] BAD_MARK   = 16'hFFF7;
  localparam logic [15:0] END_MARK   = 16'hFFF8;
  localparam logic [15:0] ALLOC_MARK = 16'hFFFF;

  localparam int unsigned SECTOR_SHIFT = 9;
  localparam int unsigned QUOT_W       = 32 - SECTOR_SHIFT;
  localparam int unsigned SPC_W        = 8;
  localparam int unsigned DIV_CNT_W    = $clog2(QUOT_W + 1);

  typedef enum logic [1:0] {
    REQ_SET   = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_MAP   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_BEYOND  = 3'd1,
    STAT_ENDED   = 3'd2,
    STAT_INVALID = 3'd3,
    STAT_FULL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_DATA_START = 2'd0,
    CFG_SPC        = 2'd1,
    CFG_COUNT      = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET,
    ST_ALLOC_TEST,
    ST_ALLOC_CHK,
    ST_FREE_START,
    ST_FREE_TEST,
    ST_FREE_CHK,
    ST_MAP,
    ST_DIV,
    ST_WALK_TEST,
    ST_WALK_CHK,
    ST_LBA,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
    logic [SPC_W-1:0]  rem;
  } div_res_t;

endpackage

FILE: design/fcce_div.sv
module fcce_div
  import fcce_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [QUOT_W-1:0] dividend,
  input  logic [SPC_W-1:0]  divisor,
  output div_res_t          res
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [QUOT_W-1:0]    q;
  logic [SPC_W-1:0]     r;
  logic [SPC_W-1:0]     d;
  logic [SPC_W:0]       r_sh;
  logic                 ge;
  logic                 done;

  assign r_sh = {r, q[QUOT_W-1]};
  assign ge   = r_sh >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        q    <= dividend;
        r    <= '0;
        d    <= divisor;
      end else if (busy) begin
        q <= {q[QUOT_W-2:0], ge};
        r <= ge ? SPC_W'(r_sh - {1'b0, d}) : r_sh[SPC_W-1:0];
        if (cnt == DIV_CNT_W'(QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  assign res.done = done;
  assign res.quot = q;
  assign res.rem  = r;

endmodule

FILE: design/fat_cluster_chain_engine.sv
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  req_type, cluster, entry_value, file_pos,
//                                        file_length
// out      output     out_valid/out_stall status, found_cluster, sector_addr, byte_in_sector
// cfg      input      cfg_write          cfg_index, cfg_data
//
// After reset the table is swept to free, one entry per cycle, over all TABLE_ENTRIES
// entries, and no request is taken during that sweep.
// One request is worked at a time over one write port and one registered read port
// of the table. Set writes one in-range entry; allocate and free test and check each visited entry.
// Map runs the 23-step offset divider and then tests and checks each chain link
// walked; a cache hit on the start cluster shortens the walk.
// The result waits in an output register, so a stalled output holds one transfer.
module fat_cluster_chain_engine
  import fcce_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [15:0] cluster,
  input  logic [15:0] entry_value,
  input  logic [31:0] file_pos,
  input  logic [31:0] file_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] found_cluster,
  output logic [31:0] sector_addr,
  output logic [8:0]  byte_in_sector,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);

  state_t state, state_next;

  logic [31:0] data_start_lba;
  logic [7:0]  clus_sectors;
  logic [11:0] cluster_count;

  logic [15:0] fat_mem [TABLE_ENTRIES];
  logic [15:0] rd_data;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0] mem_wdata;
  logic [AW-1:0] clr_idx;

  req_t        req;
  logic [15:0] start_cl;
  logic [15:0] set_val;
  logic [31:0] off;
  logic [31:0] len;
  logic [15:0] cur;
  logic [QUOT_W-1:0] walk;
  logic [QUOT_W-1:0] target;
  logic [SPC_W-1:0]  rem;
  logic [23:0] prod;

  logic        cache_valid;
  logic [15:0] cache_key;
  logic [15:0] cache_index;
  logic [15:0] cache_cluster;

  status_t     res_status;
  logic [15:0] res_found;
  logic [31:0] res_lba;

  logic [7:0]  spc_eff;
  logic        cur_ok;
  logic        set_ok;
  logic        accept;
  logic        out_free;
  logic        div_start;
  logic        cache_hit;
  div_res_t    div_res;

  function automatic logic clus_valid(logic [15:0] c, logic [11:0] cnt);
    return (c >= 16'd2) && ({1'b0, c} < ({5'b0, cnt} + 17'd2)) &&
           (32'(c) < TABLE_ENTRIES);
  endfunction

  assign spc_eff   = (clus_sectors == 8'd0) ? 8'd1 : clus_sectors;
  assign cur_ok    = clus_valid(cur, cluster_count);
  assign set_ok    = 32'(start_cl) < TABLE_ENTRIES;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cache_hit = cache_valid && (cache_key == start_cl) &&
                     clus_valid(cache_cluster, cluster_count) &&
                     ({{(QUOT_W-16){1'b0}}, cache_index} <= div_res.quot);

  fcce_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (off[31:SECTOR_SHIFT]),
    .divisor  (spc_eff),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fat_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= fat_mem[cur[AW-1:0]];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:      if (clr_idx == AW'(TABLE_ENTRIES - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (req_t'(req_type))
            REQ_SET:   state_next = ST_SET;
            REQ_ALLOC: state_next = ST_ALLOC_TEST;
            REQ_FREE:  state_next = ST_FREE_START;
            REQ_MAP:   state_next = ST_MAP;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_SET:        state_next = ST_DONE;
      ST_ALLOC_TEST: state_next = cur_ok ? ST_ALLOC_CHK : ST_DONE;
      ST_ALLOC_CHK:  state_next = (rd_data == FREE_MARK) ? ST_DONE : ST_ALLOC_TEST;
      ST_FREE_START: state_next = cur_ok ? ST_FREE_CHK : ST_DONE;
      ST_FREE_TEST:  state_next = cur_ok ? ST_FREE_CHK : ST_DONE;
      ST_FREE_CHK: begin
        if (rd_data >= END_MARK || rd_data == FREE_MARK || rd_data == BAD_MARK) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_FREE_TEST;
        end
      end
      ST_MAP:        state_next = (off >= len) ? ST_DONE : ST_DIV;
      ST_DIV:        if (div_res.done) state_next = ST_WALK_TEST;
      ST_WALK_TEST: begin
        if (walk != '0 && cur_ok) begin
          state_next = ST_WALK_CHK;
        end else if (!cur_ok) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_LBA;
        end
      end
      ST_WALK_CHK:   state_next = (rd_data >= END_MARK) ? ST_DONE : ST_WALK_TEST;
      ST_LBA:        state_next = ST_DONE;
      ST_DONE:       if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    div_start = (state == ST_MAP) && (off < len);
    mem_we    = 1'b0;
    mem_waddr = cur[AW-1:0];
    mem_wdata = FREE_MARK;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
      end
      ST_SET: begin
        mem_we    = set_ok;
        mem_waddr = start_cl[AW-1:0];
        mem_wdata = set_val;
      end
      ST_ALLOC_CHK: begin
        mem_we    = (rd_data == FREE_MARK);
        mem_wdata = ALLOC_MARK;
      end
      ST_FREE_CHK:  mem_we = 1'b1;
      default:      mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_CLEAR;
      clr_idx             <= '0;
      data_start_lba      <= '0;
      clus_sectors        <= 8'd1;
      cluster_count       <= '0;
      cache_valid         <= 1'b0;
      cache_key           <= '0;
      cache_index         <= '0;
      cache_cluster       <= '0;
      out_valid           <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (cfg_write) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DATA_START: data_start_lba      <= cfg_data;
          CFG_SPC:        clus_sectors        <= cfg_data[7:0];
          CFG_COUNT:      cluster_count       <= cfg_data[11:0];
          default:        ;
        endcase
      end
      if (accept && req_t'(req_type) != REQ_MAP) begin
        cache_valid   <= 1'b0;
        cache_key     <= '0;
        cache_index   <= '0;
        cache_cluster <= '0;
      end
      if (state == ST_WALK_TEST && walk == '0 && cur_ok) begin
        if (target[QUOT_W-1:16] == '0) begin
          cache_valid   <= 1'b1;
          cache_key     <= start_cl;
          cache_index   <= target[15:0];
          cache_cluster <= cur;
        end else begin
          cache_valid   <= 1'b0;
          cache_key     <= '0;
          cache_index   <= '0;
          cache_cluster <= '0;
        end
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        req        <= req_t'(req_type);
        start_cl   <= cluster;
        set_val    <= entry_value;
        off        <= file_pos;
        len        <= file_length;
        res_status <= STAT_OK;
        res_found  <= '0;
        res_lba    <= '0;
        cur        <= (req_t'(req_type) == REQ_ALLOC) ? 16'd2 : cluster;
      end
      ST_SET:        if (!set_ok) res_status <= STAT_INVALID;
      ST_ALLOC_TEST: if (!cur_ok) res_status <= STAT_FULL;
      ST_ALLOC_CHK: begin
        if (rd_data == FREE_MARK) begin
          res_found <= cur;
        end else begin
          cur <= cur + 16'd1;
        end
      end
      ST_FREE_START: if (!cur_ok) res_status <= STAT_INVALID;
      ST_FREE_CHK:   cur <= rd_data;
      ST_MAP:        if (off >= len) res_status <= STAT_BEYOND;
      ST_DIV: begin
        if (div_res.done) begin
          target <= div_res.quot;
          rem    <= div_res.rem;
          if (cache_hit) begin
            cur  <= cache_cluster;
            walk <= div_res.quot - {{(QUOT_W-16){1'b0}}, cache_index};
          end else begin
            walk <= div_res.quot;
          end
        end
      end
      ST_WALK_TEST: begin
        if (!cur_ok) begin
          res_status <= STAT_INVALID;
        end else if (walk == '0) begin
          prod      <= (cur - 16'd2) * spc_eff;
          res_found <= cur;
        end
      end
      ST_WALK_CHK: begin
        cur  <= rd_data;
        walk <= walk - 1'b1;
        if (rd_data >= END_MARK) res_status <= STAT_ENDED;
      end
      ST_LBA:  res_lba <= data_start_lba + 32'(prod) + 32'(rem);
      ST_DONE: begin
        if (out_free) begin
          status         <= res_status;
          found_cluster  <= res_found;
          sector_addr    <= res_lba;
          byte_in_sector <= (req == REQ_MAP && res_status == STAT_OK) ?
                            off[SECTOR_SHIFT-1:0] : '0;
        end
      end
      default: ;
    endcase
  end

  a_mem_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLEAR || state == ST_SET || state == ST_ALLOC_CHK ||
                state == ST_FREE_CHK))
    else $error("table written outside a write state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == ST_DIV)
    else $error("divider finished while not awaited");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted transfer left no work");

  a_found_is_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STAT_OK && found_cluster != 16'd0) |-> found_cluster >= 16'd2)
    else $error("reported cluster below the data region");

endmodule
